[sv/tst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tst_pkg: touch slot table shared types
// command and status codes, sequencer states and transfer payload structs
// ----------------------------------------------------------------------------
package tst_pkg;

    localparam int KEY_W    = 32;
    localparam int SLOT_W   = 4;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ATTACH      = 3'd0,
        CMD_DETACH_KEY  = 3'd1,
        CMD_DETACH_SLOT = 3'd2,
        CMD_LOOKUP      = 3'd3,
        CMD_OVERWRITE   = 3'd4
    } tst_cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOT_FND  = 2'd1,
        ST_FULL     = 2'd2,
        ST_RANGE    = 2'd3
    } tst_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE
    } tst_state_t;

    typedef struct packed {
        logic        [CMD_W-1:0]  cmd;
        logic signed [KEY_W-1:0]  key;
        logic        [SLOT_W-1:0] slot;
    } tst_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_index;
        logic [STATUS_W-1:0] status;
        logic [SIZE_W-1:0]   table_size;
    } tst_rsp_t;

endpackage
`default_nettype wire

[sv/tst_key_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tst_key_mem: key store
// one write port and one registered read port
// ----------------------------------------------------------------------------
module tst_key_mem
    import tst_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [KEY_W-1:0] rd_data,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [KEY_W-1:0] wr_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[sv/tst_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tst_seq: scan sequencer
// walks the used slots with one key compare per cycle, then applies the command
// ----------------------------------------------------------------------------
module tst_seq
    import tst_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int AW    = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire tst_req_t         req,
    output logic                  busy,
    input  wire logic             out_free,
    output logic                  done,
    output tst_rsp_t              res,
    output logic                  rd_en,
    output logic [AW-1:0]         rd_addr,
    input  wire logic [KEY_W-1:0] rd_data,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [KEY_W-1:0]      wr_data
);

    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int EXT_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    tst_state_t       state_reg, state_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pidx_reg, pidx_next;
    logic             found_reg, found_next;
    logic [AW-1:0]    hit_reg, hit_next;
    logic [CNT_W-1:0] used_reg, used_next;

    logic [KEY_W-1:0] target;
    logic             match;
    logic             scan_cmd;
    logic [EXT_W-1:0] used_ext, slot_ext, hit_ext, rel_ext, idx_ext, new_ext;
    logic             slot_ok, trim;
    logic [CNT_W-1:0] used_new;
    tst_status_t      status;

    // shared compare unit: attach hunts for a hole (key 0)
    assign target = (cmd_reg == CMD_ATTACH) ? '0 : key_reg;
    assign match  = pend_reg && (rd_data == target);

    assign scan_cmd = (req.cmd == CMD_ATTACH) || (req.cmd == CMD_DETACH_KEY) ||
                      (req.cmd == CMD_LOOKUP);

    assign used_ext = EXT_W'(used_reg);
    assign slot_ext = EXT_W'(slot_reg);
    assign hit_ext  = EXT_W'(hit_reg);
    assign rel_ext  = (cmd_reg == CMD_DETACH_SLOT) ? slot_ext : hit_ext;
    assign slot_ok  = slot_ext < used_ext;
    assign trim     = (rel_ext + EXT_W'(1)) == used_ext;
    assign new_ext  = EXT_W'(used_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        slot_reg <= slot_next;
        pidx_reg <= pidx_next;
        hit_reg  <= hit_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        slot_next  = slot_reg;
        ptr_next   = ptr_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        found_next = found_reg;
        hit_next   = hit_reg;
        used_next  = used_reg;
        used_new   = used_reg;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = rel_ext[AW-1:0];
        wr_data    = '0;
        idx_ext    = '0;
        status     = ST_OK;
        done       = 1'b0;
        busy       = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = req.cmd;
                    key_next   = req.key;
                    slot_next  = req.slot;
                    ptr_next   = '0;
                    found_next = 1'b0;
                    state_next = scan_cmd ? S_SCAN : S_RESOLVE;
                end
            end

            S_SCAN:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    hit_next   = pidx_reg;
                    state_next = S_RESOLVE;
                end
                else if (ptr_reg < used_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    pidx_next = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    found_next = 1'b0;
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                case (cmd_reg)
                    CMD_ATTACH:
                    begin
                        if (found_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = hit_reg;
                            wr_data = key_reg;
                            idx_ext = hit_ext;
                        end
                        else if (used_reg < CNT_W'(SLOTS))
                        begin
                            wr_en    = 1'b1;
                            wr_addr  = used_reg[AW-1:0];
                            wr_data  = key_reg;
                            idx_ext  = used_ext;
                            used_new = used_reg + CNT_W'(1);
                        end
                        else
                        begin
                            status = ST_FULL;
                        end
                    end
                    CMD_DETACH_KEY, CMD_DETACH_SLOT:
                    begin
                        if ((cmd_reg == CMD_DETACH_KEY) ? found_reg : slot_ok)
                        begin
                            // last slot trims the table, any other becomes a hole
                            if (trim)
                            begin
                                used_new = used_reg - CNT_W'(1);
                            end
                            else
                            begin
                                wr_en = 1'b1;
                            end
                        end
                        else
                        begin
                            status = (cmd_reg == CMD_DETACH_KEY) ? ST_NOT_FND : ST_RANGE;
                        end
                    end
                    CMD_LOOKUP:
                    begin
                        if (found_reg)
                        begin
                            idx_ext = hit_ext;
                        end
                        else
                        begin
                            status = ST_NOT_FND;
                        end
                    end
                    CMD_OVERWRITE:
                    begin
                        if (slot_ok)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = slot_ext[AW-1:0];
                            wr_data = key_reg;
                        end
                        else
                        begin
                            status = ST_RANGE;
                        end
                    end
                    default:
                    begin
                        status = ST_OK;
                    end
                endcase

                if (out_free)
                begin
                    done       = 1'b1;
                    used_next  = used_new;
                    state_next = S_IDLE;
                end
                else
                begin
                    wr_en = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.slot_index = idx_ext[SLOT_W-1:0];
        res.status     = status;
        res.table_size = new_ext[SIZE_W-1:0];
    end

endmodule
`default_nettype wire

[sv/touch_slot_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// touch_slot_table: touch key slot allocator
// keeps active touch keys in slots whose index is the touch id
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  req     | in        | req_valid/req_stall| tst_req_t: cmd, key, slot
//  rsp     | out       | rsp_valid/rsp_stall| tst_rsp_t: slot_index, status,
//          |           |                    |            table_size
//
//  attach, detach-by-key and lookup scan the key memory one slot per cycle
//  through its single read port, ending early on a hit; detach-by-slot and
//  overwrite skip the scan and go straight to the result
//  req_stall stays high from the cycle after a req transfer until the result
//  is loaded into the rsp register
//  a result waits in the rsp register under rsp_stall while the next req is
//  taken; the sequencer holds its result until that register is free
//  reset empties the table at once; the key memory needs no clearing
// ----------------------------------------------------------------------------
module touch_slot_table
    import tst_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_stall,
    input  wire tst_req_t req_data,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output tst_rsp_t      rsp_data
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // sequencer handshake
    logic     busy;
    logic     start;
    logic     out_free;
    logic     done;
    tst_rsp_t res;

    // key memory port
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_data;

    // output register
    logic     rsp_valid_reg, rsp_valid_next;
    tst_rsp_t rsp_data_reg, rsp_data_next;

    // one command at a time; a req transfer starts the sequencer
    assign req_stall = busy;
    assign start     = req_valid && !busy;

    // the output register frees up when empty or being drained this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    tst_seq #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req_data),
        .busy     (busy),
        .out_free (out_free),
        .done     (done),
        .res      (res),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    tst_key_mem #(
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_key_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (done)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef NO_ASSERTIONS
    // a transfer always launches the sequencer, so the next cycle is stalled
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("req accepted without sequencer going busy");

    // an error result never carries a slot index
    a_err_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status != ST_OK) |-> rsp_data.slot_index == '0)
        else $error("error result with nonzero slot_index");

    // a new result only lands when the output register is free
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_free)
        else $error("result overwrote a pending response");
`endif

endmodule
`default_nettype wire
